@@ rtl/core/bfte_pkg.sv @@
// shared types, codes and helpers of the tape machine executor
`default_nettype none
package bfte_pkg;

   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_RESTART = 2'd1;
   localparam logic [1:0] KIND_STEP    = 2'd2;
   localparam logic [1:0] KIND_CLEAR   = 2'd3;

   localparam logic [3:0] OP_RIGHT = 4'd0;
   localparam logic [3:0] OP_LEFT  = 4'd1;
   localparam logic [3:0] OP_INC   = 4'd2;
   localparam logic [3:0] OP_DEC   = 4'd3;
   localparam logic [3:0] OP_OUT   = 4'd4;
   localparam logic [3:0] OP_IN    = 4'd5;
   localparam logic [3:0] OP_OPEN  = 4'd6;
   localparam logic [3:0] OP_CLOSE = 4'd7;
   localparam logic [3:0] OP_NONE  = 4'd8;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_OUTPUT    = 3'd1;
   localparam logic [2:0] ST_HALTED    = 3'd2;
   localparam logic [2:0] ST_UNDER     = 3'd3;
   localparam logic [2:0] ST_OVER      = 3'd4;
   localparam logic [2:0] ST_STACK     = 3'd5;
   localparam logic [2:0] ST_UNMATCHED = 3'd6;
   localparam logic [2:0] ST_FULL      = 3'd7;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP,
      S_SCAN_RD,
      S_SCAN_EV,
      S_CLEAR
   } state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] src_char;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  out_byte;
      logic [11:0] repeat_res;
      logic [10:0] pc;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic [2:0] op;
   } prog_ctl_type;

   typedef struct packed {
      logic       wr;
      logic       clear_start;
      logic [7:0] wr_data;
   } tape_ctl_type;

   function automatic logic [3:0] char_to_op(input logic [7:0] c);
      logic [3:0] op;
      unique case (c)
         8'h3E:   op = OP_RIGHT;
         8'h3C:   op = OP_LEFT;
         8'h2B:   op = OP_INC;
         8'h2D:   op = OP_DEC;
         8'h2E:   op = OP_OUT;
         8'h2C:   op = OP_IN;
         8'h5B:   op = OP_OPEN;
         8'h5D:   op = OP_CLOSE;
         default: op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/bf_tape_machine_executor_top.sv @@
// tape machine executor: command decode, step sequencer and loop stack
// load, halted and sticky error words: result registered in the cycle after start
// ordinary step: program and tape read, then modify and write back
// close bracket: extra loop stack read in S_POP; skip scan: S_SCAN_RD then S_SCAN_EV per entry scanned
// restart and clear: answered once the one-cell-a-cycle tape sweep ends
// reset: synchronous; busy stays high while the tape is swept
`default_nettype none
module bf_tape_machine_executor_top #(
   parameter int PROG_DEPTH  = 1024,
   parameter int TAPE_CELLS  = 4096,
   parameter int STACK_DEPTH = 64,
   parameter int RUN_MAX     = 4095
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire bfte_pkg::req_type req_data,
   output logic                   busy,
   output logic                   rsp_valid,
   output bfte_pkg::rsp_type      rsp_data
);
   import bfte_pkg::*;

   localparam int PW   = $clog2(PROG_DEPTH);
   localparam int PCW  = PW + 1;
   localparam int CW   = $clog2(RUN_MAX + 1);
   localparam int HW   = $clog2(TAPE_CELLS);
   localparam int SW   = $clog2(STACK_DEPTH);
   localparam int SPW  = SW + 1;
   localparam int SUMW = ((HW > CW) ? HW : CW) + 1;

   state_type      state_ff, state_in;
   logic [PCW-1:0] pc_ff, pc_in, scan_ff, scan_in, depth_ff, depth_in;
   logic [HW-1:0]  head_ff, head_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [CW-1:0]  rl_ff, rl_in, rem, rem_m1;
   logic [2:0]     sticky_ff, sticky_in;
   logic [7:0]     inb_ff, inb_in;
   logic           notify_ff, notify_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   prog_ctl_type   prog_ctl;
   logic [PCW-1:0] prog_addr, prog_len;
   logic [2:0]     prog_op;
   logic [CW-1:0]  prog_cnt;
   logic           load_full;
   tape_ctl_type   tape_ctl;
   logic [7:0]     tape_byte;
   logic           tape_clearing;

   logic [PCW-1:0] stack_mem [STACK_DEPTH];
   logic [PCW-1:0] stack_rd_ff;
   logic           stack_wr;
   logic [SW-1:0]  stack_rd_addr;

   logic [SUMW-1:0] sum;
   logic [3:0]      load_op;
   logic [2:0]      status;
   logic            done;

   bfte_prog_store #(.PROG_DEPTH(PROG_DEPTH), .RUN_MAX(RUN_MAX)) u_prog (
      .clock(clock), .reset(reset), .ctl(prog_ctl), .rd_addr(prog_addr),
      .rd_op(prog_op), .rd_cnt(prog_cnt), .length(prog_len), .load_full(load_full)
   );

   bfte_tape_store #(.TAPE_CELLS(TAPE_CELLS)) u_tape (
      .clock(clock), .reset(reset), .ctl(tape_ctl), .addr(head_ff),
      .rd_data(tape_byte), .clearing(tape_clearing)
   );

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      scan_in = scan_ff;
      depth_in = depth_ff;
      head_in = head_ff;
      sp_in = sp_ff;
      rl_in = rl_ff;
      sticky_in = sticky_ff;
      inb_in = inb_ff;
      notify_in = notify_ff;
      prog_ctl = '0;
      load_op = char_to_op(req_data.src_char);
      prog_ctl.op = load_op[2:0];
      tape_ctl = '0;
      tape_ctl.wr_data = inb_ff;
      stack_wr = 1'b0;
      stack_rd_addr = SW'(sp_ff - SPW'(1));
      prog_addr = (state_ff == S_SCAN_RD) ? scan_ff : pc_ff;
      sum = SUMW'(head_ff) + SUMW'(prog_cnt);
      rem = (rl_ff == '0) ? prog_cnt : rl_ff;
      rem_m1 = rem - CW'(1);
      status = ST_OK;
      done = 1'b0;
      rsp_in = rsp_ff;
      rsp_in.out_byte = 8'd0;
      rsp_in.repeat_res = 12'd0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_data.kind)
                  KIND_LOAD: begin
                     done = 1'b1;
                     if (load_op != OP_NONE) begin
                        prog_ctl.load = 1'b1;
                        if (load_full) begin
                           status = ST_FULL;
                           sticky_in = ST_FULL;
                        end
                     end
                  end
                  KIND_RESTART, KIND_CLEAR: begin
                     pc_in = '0;
                     head_in = '0;
                     sp_in = '0;
                     rl_in = '0;
                     if (req_data.kind == KIND_CLEAR || sticky_ff != ST_FULL) begin
                        sticky_in = ST_OK;
                     end
                     prog_ctl.clear = (req_data.kind == KIND_CLEAR);
                     tape_ctl.clear_start = 1'b1;
                     notify_in = 1'b1;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     inb_in = req_data.in_byte;
                     if (sticky_ff != ST_OK) begin
                        done = 1'b1;
                        status = sticky_ff;
                     end else if (pc_ff >= prog_len) begin
                        done = 1'b1;
                        status = ST_HALTED;
                     end else begin
                        state_in = S_EXEC;
                     end
                  end
               endcase
            end
         end
         S_EXEC: begin
            done = 1'b1;
            case (prog_op)
               OP_RIGHT[2:0]: begin
                  if (sum >= SUMW'(TAPE_CELLS)) begin
                     status = ST_OVER;
                  end else begin
                     head_in = sum[HW-1:0];
                     pc_in = pc_ff + PCW'(1);
                  end
               end
               OP_LEFT[2:0]: begin
                  if (SUMW'(prog_cnt) > SUMW'(head_ff)) begin
                     status = ST_UNDER;
                  end else begin
                     head_in = head_ff - HW'(prog_cnt);
                     pc_in = pc_ff + PCW'(1);
                  end
               end
               OP_INC[2:0], OP_DEC[2:0]: begin
                  tape_ctl.wr = 1'b1;
                  tape_ctl.wr_data = (prog_op == OP_INC[2:0]) ? tape_byte + 8'(prog_cnt)
                                                              : tape_byte - 8'(prog_cnt);
                  pc_in = pc_ff + PCW'(1);
               end
               OP_OUT[2:0]: begin
                  status = ST_OUTPUT;
                  rsp_in.out_byte = tape_byte;
                  rsp_in.repeat_res = 12'(prog_cnt);
                  pc_in = pc_ff + PCW'(1);
               end
               OP_IN[2:0]: begin
                  tape_ctl.wr = 1'b1;
                  rl_in = rem_m1;
                  if (rem_m1 == '0) begin
                     pc_in = pc_ff + PCW'(1);
                  end
               end
               OP_OPEN[2:0]: begin
                  if (tape_byte == 8'd0) begin
                     done = 1'b0;
                     scan_in = pc_ff + PCW'(1);
                     depth_in = PCW'(1);
                     state_in = S_SCAN_RD;
                  end else if (sp_ff >= SPW'(STACK_DEPTH)) begin
                     status = ST_STACK;
                  end else begin
                     stack_wr = 1'b1;
                     sp_in = sp_ff + SPW'(1);
                     pc_in = pc_ff + PCW'(1);
                  end
               end
               default: begin
                  if (sp_ff == '0) begin
                     status = ST_UNMATCHED;
                  end else begin
                     done = 1'b0;
                     state_in = S_POP;
                  end
               end
            endcase
            if (status == ST_OVER || status == ST_UNDER || status == ST_STACK
                || status == ST_UNMATCHED) begin
               sticky_in = status;
            end
         end
         S_POP: begin
            done = 1'b1;
            pc_in = stack_rd_ff;
            sp_in = sp_ff - SPW'(1);
         end
         S_SCAN_RD: begin
            if (scan_ff >= prog_len) begin
               done = 1'b1;
               status = ST_UNMATCHED;
               sticky_in = ST_UNMATCHED;
            end else begin
               state_in = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            depth_in = depth_ff;
            if (prog_op == OP_OPEN[2:0]) begin
               depth_in = depth_ff + PCW'(1);
            end else if (prog_op == OP_CLOSE[2:0]) begin
               depth_in = depth_ff - PCW'(1);
            end
            if (depth_in == '0) begin
               done = 1'b1;
               pc_in = scan_ff + PCW'(1);
            end else begin
               scan_in = scan_ff + PCW'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_CLEAR: begin
            if (!tape_clearing) begin
               done = notify_ff;
               notify_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (done) begin
         state_in = S_IDLE;
      end
      rsp_valid_in = done;
      rsp_in.status = status;
      rsp_in.pc = 11'(pc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pc_ff <= '0;
         head_ff <= '0;
         sp_ff <= '0;
         rl_ff <= '0;
         sticky_ff <= ST_OK;
         notify_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         head_ff <= head_in;
         sp_ff <= sp_in;
         rl_ff <= rl_in;
         sticky_ff <= sticky_in;
         notify_ff <= notify_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff <= scan_in;
      depth_ff <= depth_in;
      inb_ff <= inb_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (stack_wr) begin
         stack_mem[sp_ff[SW-1:0]] <= pc_ff;
      end
      stack_rd_ff <= stack_mem[stack_rd_addr];
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/core/bfte_prog_store.sv @@
// run-length program memory with load merging and registered read port
`default_nettype none
module bfte_prog_store #(
   parameter int PROG_DEPTH = 1024,
   parameter int RUN_MAX    = 4095,
   parameter int PW  = $clog2(PROG_DEPTH),
   parameter int PCW = PW + 1,
   parameter int CW  = $clog2(RUN_MAX + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bfte_pkg::prog_ctl_type ctl,
   input  wire logic [PCW-1:0]        rd_addr,
   output logic [2:0]                 rd_op,
   output logic [CW-1:0]              rd_cnt,
   output logic [PCW-1:0]             length,
   output logic                       load_full
);
   import bfte_pkg::*;

   logic [2+CW:0]  mem [PROG_DEPTH];
   logic [2+CW:0]  rd_ff;
   logic [PCW-1:0] len_ff, len_in;
   logic [2:0]     last_op_ff, last_op_in;
   logic [CW-1:0]  last_cnt_ff, last_cnt_in;
   logic           merge, room, wr_en;
   logic [PCW-1:0] wr_addr;
   logic [2+CW:0]  wr_data;

   always_comb begin
      merge = (ctl.op < OP_OPEN[2:0]) && (len_ff != '0) && (last_op_ff == ctl.op)
              && (last_cnt_ff < CW'(RUN_MAX));
      room = len_ff < PCW'(PROG_DEPTH);
      load_full = ctl.load && !merge && !room;
      len_in = len_ff;
      last_op_in = last_op_ff;
      last_cnt_in = last_cnt_ff;
      wr_en = 1'b0;
      wr_addr = len_ff;
      wr_data = {ctl.op, CW'(1)};
      if (ctl.clear) begin
         len_in = '0;
      end else if (ctl.load && merge) begin
         wr_en = 1'b1;
         wr_addr = len_ff - PCW'(1);
         last_cnt_in = last_cnt_ff + CW'(1);
         wr_data = {ctl.op, last_cnt_in};
      end else if (ctl.load && room) begin
         wr_en = 1'b1;
         len_in = len_ff + PCW'(1);
         last_op_in = ctl.op;
         last_cnt_in = CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
      last_op_ff <= last_op_in;
      last_cnt_ff <= last_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[PW-1:0]] <= wr_data;
      end
      rd_ff <= mem[rd_addr[PW-1:0]];
   end

   assign rd_op  = rd_ff[2+CW:CW];
   assign rd_cnt = rd_ff[CW-1:0];
   assign length = len_ff;

endmodule
`default_nettype wire

@@ rtl/core/bfte_tape_store.sv @@
// tape memory with clearing sweep after reset and on request
`default_nettype none
module bfte_tape_store #(
   parameter int TAPE_CELLS = 4096,
   parameter int HW = $clog2(TAPE_CELLS)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bfte_pkg::tape_ctl_type ctl,
   input  wire logic [HW-1:0]          addr,
   output logic [7:0]                  rd_data,
   output logic                        clearing
);
   import bfte_pkg::*;

   logic [7:0]    mem [TAPE_CELLS];
   logic [7:0]    rd_ff;
   logic          clearing_ff, clearing_in;
   logic [HW-1:0] clr_ff, clr_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_in = clr_ff;
      if (ctl.clear_start) begin
         clearing_in = 1'b1;
         clr_in = '0;
      end else if (clearing_ff) begin
         if (clr_ff == HW'(TAPE_CELLS - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clr_in = clr_ff + HW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_ff] <= 8'd0;
      end else if (ctl.wr) begin
         mem[addr] <= ctl.wr_data;
      end
      rd_ff <= mem[addr];
   end

   assign rd_data  = rd_ff;
   assign clearing = clearing_ff;

endmodule
`default_nettype wire

@@ rtl/core/bfte_checker.sv @@
// port-level assertions for the tape machine executor, bound to the top level
`default_nettype none
module bfte_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire bfte_pkg::req_type req_data,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire bfte_pkg::rsp_type rsp_data
);
   import bfte_pkg::*;

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("accepted word neither answered nor in progress");

   a_word_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word shown while busy");

   a_plain_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OUTPUT |->
         rsp_data.out_byte == 8'd0 && rsp_data.repeat_res == 12'd0)
      else $error("byte or repeat set on non-output word");

   a_load_no_halt: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.kind == KIND_LOAD |=>
         rsp_valid && rsp_data.status != ST_HALTED)
      else $error("load answered wrongly");

endmodule

bind bf_tape_machine_executor_top bfte_checker u_bfte_checker (.*);
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the tape machine executor
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import bfte_pkg::*;

   localparam int PROG_DEPTH  = 1024;
   localparam int TAPE_CELLS  = 4096;
   localparam int STACK_DEPTH = 64;
   localparam int RUN_MAX     = 4095;
   localparam int RANDOM_WORDS = 1550;
   localparam int CALM_TAIL    = 200;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   bf_tape_machine_executor_top #(
      .PROG_DEPTH(PROG_DEPTH), .TAPE_CELLS(TAPE_CELLS),
      .STACK_DEPTH(STACK_DEPTH), .RUN_MAX(RUN_MAX)
   ) uut (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // executor shadow state
   logic [3:0]  entry_op  [PROG_DEPTH];
   int          entry_cnt [PROG_DEPTH];
   int          prog_len;
   int          exec_pc;
   logic [7:0]  cells [TAPE_CELLS];
   int          head_pos;
   int          open_idx [STACK_DEPTH];
   int          open_depth;
   int          reads_pending;
   logic [2:0]  sticky;

   rsp_type     pending_words[$];
   int          mismatches;
   int          words_sent;
   bit          idle_on;
   logic [2:0]  last_status;
   byte         prog_text[$];

   function automatic logic [3:0] op_of(input logic [7:0] c);
      case (c)
         ">":     return OP_RIGHT;
         "<":     return OP_LEFT;
         "+":     return OP_INC;
         "-":     return OP_DEC;
         ".":     return OP_OUT;
         ",":     return OP_IN;
         "[":     return OP_OPEN;
         "]":     return OP_CLOSE;
         default: return OP_NONE;
      endcase
   endfunction

   function void rewind_run();
      exec_pc = 0;
      head_pos = 0;
      open_depth = 0;
      reads_pending = 0;
      for (int i = 0; i < TAPE_CELLS; i++) cells[i] = 8'd0;
      if (sticky != ST_FULL) sticky = ST_OK;
   endfunction

   function logic [2:0] raise(input logic [2:0] code);
      sticky = code;
      return code;
   endfunction

   function logic [2:0] load_char(input logic [7:0] c);
      logic [3:0] op;
      op = op_of(c);
      if (op == OP_NONE) return ST_OK;
      if (op != OP_OPEN && op != OP_CLOSE && prog_len > 0)
         if (entry_op[prog_len-1] == op && entry_cnt[prog_len-1] < RUN_MAX) begin
            entry_cnt[prog_len-1]++;
            return ST_OK;
         end
      if (prog_len >= PROG_DEPTH) return raise(ST_FULL);
      entry_op[prog_len] = op;
      entry_cnt[prog_len] = 1;
      prog_len++;
      return ST_OK;
   endfunction

   function logic [2:0] exec_entry(input logic [7:0] b, output logic [7:0] ob,
                                   output int rep);
      int cnt, i, depth;
      ob = 8'd0;
      rep = 0;
      if (sticky != ST_OK) return sticky;
      if (exec_pc >= prog_len) return ST_HALTED;
      cnt = entry_cnt[exec_pc];
      case (entry_op[exec_pc])
         OP_RIGHT: begin
            if (head_pos + cnt >= TAPE_CELLS) return raise(ST_OVER);
            head_pos += cnt;
         end
         OP_LEFT: begin
            if (cnt > head_pos) return raise(ST_UNDER);
            head_pos -= cnt;
         end
         OP_INC: cells[head_pos] = cells[head_pos] + cnt[7:0];
         OP_DEC: cells[head_pos] = cells[head_pos] - cnt[7:0];
         OP_OUT: begin
            ob = cells[head_pos];
            rep = cnt;
            exec_pc++;
            return ST_OUTPUT;
         end
         OP_IN: begin
            if (reads_pending == 0) reads_pending = cnt;
            cells[head_pos] = b;
            reads_pending--;
            if (reads_pending != 0) return ST_OK;
         end
         OP_OPEN: begin
            if (cells[head_pos] == 8'd0) begin
               depth = 0;
               for (i = exec_pc; i < prog_len; i++) begin
                  if (entry_op[i] == OP_OPEN) depth++;
                  else if (entry_op[i] == OP_CLOSE) depth--;
                  if (depth == 0) break;
               end
               if (i >= prog_len) return raise(ST_UNMATCHED);
               exec_pc = i + 1;
               return ST_OK;
            end
            if (open_depth >= STACK_DEPTH) return raise(ST_STACK);
            open_idx[open_depth++] = exec_pc;
         end
         default: begin
            if (open_depth == 0) return raise(ST_UNMATCHED);
            open_depth--;
            exec_pc = open_idx[open_depth];
            return ST_OK;
         end
      endcase
      exec_pc++;
      return ST_OK;
   endfunction

   function rsp_type next_word(input req_type r);
      rsp_type w;
      logic [7:0] ob;
      int rep;
      w = '0;
      case (r.kind)
         KIND_LOAD:    w.status = load_char(r.src_char);
         KIND_RESTART: rewind_run();
         KIND_STEP: begin
            w.status = exec_entry(r.in_byte, ob, rep);
            w.out_byte = ob;
            w.repeat_res = rep[11:0];
         end
         default: begin
            prog_len = 0;
            sticky = ST_OK;
            rewind_run();
         end
      endcase
      w.pc = exec_pc[10:0];
      return w;
   endfunction

   task automatic send_word(input logic [1:0] k, input logic [7:0] c, input logic [7:0] b,
                            input bit typed, input rsp_type typed_word);
      rsp_type w;
      if (idle_on && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 13)) begin
            @(negedge clock);
            start = 1'b0;
            req_data = req_type'($urandom);
         end
      @(negedge clock);
      start = 1'b1;
      req_data = '{kind: k, src_char: c, in_byte: b};
      do @(posedge clock); while (busy);
      w = next_word(req_data);
      last_status = w.status;
      pending_words.push_back(typed ? typed_word : w);
      words_sent++;
   endtask

   task automatic send(input logic [1:0] k, input logic [7:0] c, input logic [7:0] b);
      send_word(k, c, b, 1'b0, '0);
   endtask

   task automatic load_text();
      foreach (prog_text[i]) send(KIND_LOAD, prog_text[i], 8'($urandom));
   endtask

   task automatic run_steps(input int limit);
      int n;
      n = 0;
      do begin
         if ($urandom_range(0, 19) == 0) send(KIND_LOAD, 8'($urandom), 8'($urandom));
         else send(KIND_STEP, 8'($urandom), 8'($urandom));
         n++;
      end while (n < limit && (last_status == ST_OK || last_status == ST_OUTPUT));
      send(KIND_STEP, 8'($urandom), 8'($urandom));
   endtask

   task automatic make_program();
      string cmds;
      int len, opened;
      cmds = "><+-.,";
      prog_text.delete();
      opened = 0;
      len = $urandom_range(3, 22);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               prog_text.push_back("[");
               opened++;
            end
            3, 4, 5: if (opened > 0 || $urandom_range(0, 5) == 0) begin
               prog_text.push_back("]");
               if (opened > 0) opened--;
            end
            6: prog_text.push_back(byte'($urandom));
            7: prog_text.push_back("-");
            default: begin
               byte ch;
               ch = cmds[$urandom_range(0, 5)];
               repeat ($urandom_range(1, 3)) prog_text.push_back(ch);
            end
         endcase
      end
      if ($urandom_range(0, 5) != 0) repeat (opened) prog_text.push_back("]");
   endtask

   typedef struct {
      logic [1:0] kind;
      logic [7:0] ch;
      logic [7:0] ib;
      bit         typed;
      rsp_type    word;
   } row_type;

   row_type script[] = '{
      '{KIND_STEP,    8'h00, 8'h00, 1, '{ST_HALTED, 8'd0, 12'd0, 11'd0}},
      '{KIND_LOAD,    "a",   8'h00, 1, '{ST_OK, 8'd0, 12'd0, 11'd0}},
      '{KIND_LOAD,    8'hFF, 8'hFF, 1, '{ST_OK, 8'd0, 12'd0, 11'd0}},
      '{KIND_LOAD,    "+",   8'h00, 0, '0},
      '{KIND_LOAD,    "+",   8'h00, 0, '0},
      '{KIND_LOAD,    ".",   8'h00, 0, '0},
      '{KIND_LOAD,    ">",   8'h00, 0, '0},
      '{KIND_LOAD,    ",",   8'h00, 0, '0},
      '{KIND_STEP,    8'h00, 8'h00, 0, '0},
      '{KIND_STEP,    8'h00, 8'h00, 1, '{ST_OUTPUT, 8'd2, 12'd1, 11'd2}},
      '{KIND_STEP,    8'h00, 8'h00, 0, '0},
      '{KIND_STEP,    8'h00, 8'hFF, 0, '0},
      '{KIND_STEP,    8'h00, 8'h00, 1, '{ST_HALTED, 8'd0, 12'd0, 11'd4}},
      '{KIND_LOAD,    "<",   8'h00, 0, '0},
      '{KIND_LOAD,    "<",   8'h00, 0, '0},
      '{KIND_STEP,    8'h00, 8'h00, 1, '{ST_UNDER, 8'd0, 12'd0, 11'd4}},
      '{KIND_STEP,    8'h00, 8'h00, 1, '{ST_UNDER, 8'd0, 12'd0, 11'd4}},
      '{KIND_RESTART, 8'h00, 8'h00, 1, '{ST_OK, 8'd0, 12'd0, 11'd0}},
      '{KIND_LOAD,    "]",   8'h00, 0, '0},
      '{KIND_LOAD,    "[",   8'h00, 0, '0},
      '{KIND_STEP,    8'h00, 8'h00, 0, '0},
      '{KIND_CLEAR,   8'h00, 8'h00, 1, '{ST_OK, 8'd0, 12'd0, 11'd0}},
      '{KIND_LOAD,    "]",   8'h00, 0, '0},
      '{KIND_STEP,    8'h00, 8'h00, 1, '{ST_UNMATCHED, 8'd0, 12'd0, 11'd0}},
      '{KIND_CLEAR,   8'h00, 8'h00, 1, '{ST_OK, 8'd0, 12'd0, 11'd0}}
   };

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d got %0d at %0t", name, exp_v, act_v, $time);
      end
   endtask

   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word at %0t", $time);
         end else begin
            w = pending_words.pop_front();
            check_field("status", w.status, rsp_data.status);
            check_field("out_byte", w.out_byte, rsp_data.out_byte);
            check_field("repeat_res", w.repeat_res, rsp_data.repeat_res);
            check_field("pc", w.pc, rsp_data.pc);
         end
      end
   end

   initial begin
      #200_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int phase;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      mismatches = 0;
      words_sent = 0;
      idle_on = 1'b1;
      prog_len = 0;
      sticky = ST_OK;
      rewind_run();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i])
         send_word(script[i].kind, script[i].ch, script[i].ib, script[i].typed,
                   script[i].word);

      words_sent = 0;
      phase = 0;
      while (words_sent < RANDOM_WORDS) begin
         idle_on = (words_sent < RANDOM_WORDS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         send(KIND_CLEAR, 8'($urandom), 8'($urandom));
         case (phase)
            2: begin
               // long output run
               prog_text.delete();
               repeat (60) prog_text.push_back(".");
               load_text();
               run_steps(5);
            end
            5: begin
               // fill the store, then overflow it
               prog_text.delete();
               for (int i = 0; i <= PROG_DEPTH; i++) prog_text.push_back(i[0] ? "-" : "+");
               load_text();
               run_steps(3);
               send(KIND_RESTART, 8'($urandom), 8'($urandom));
               run_steps(2);
            end
            8: begin
               // nesting deeper than the loop stack
               prog_text.delete();
               prog_text.push_back("+");
               repeat (STACK_DEPTH + 1) prog_text.push_back("[");
               load_text();
               run_steps(STACK_DEPTH + 10);
            end
            11: begin
               // long move right, then a longer move left
               prog_text.delete();
               repeat (100) prog_text.push_back(">");
               prog_text.push_back("+");
               repeat (101) prog_text.push_back("<");
               load_text();
               run_steps(6);
            end
            default: begin
               make_program();
               load_text();
               run_steps(50);
               if ($urandom_range(0, 2) == 0) begin
                  send(KIND_RESTART, 8'($urandom), 8'($urandom));
                  run_steps(30);
               end
            end
         endcase
         phase++;
      end

      @(negedge clock);
      start = 1'b0;
      while (pending_words.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
rtl/core/bfte_pkg.sv
rtl/core/bfte_prog_store.sv
rtl/core/bfte_tape_store.sv
rtl/core/bf_tape_machine_executor_top.sv
rtl/core/bfte_checker.sv
tb/tb.sv
